// ===== hdl/tevq_pkg.sv =====
// Shared types and constants for the timed event queue.
// Used by timed_event_queue and its port checker; depends on nothing.
`default_nettype none

package tevq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ID_W   = 32;
    localparam int TIME_W = 48;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 3;
    // Entry layout: {execute_at, arrive_id, event_id}
    localparam int ENTRY_W = TIME_W + 2 * ID_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_SCHEDULE = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_POP      = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_ID    = 3'd1,
        STAT_IN_PAST   = 3'd2,
        STAT_DUPLICATE = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_FULL      = 3'd5,
        STAT_NONE_DUE  = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DONE = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    // Sort key: time with the sign bit flipped, then arrival id, then event id.
    function automatic logic [ENTRY_W-1:0] sort_key(input logic [ENTRY_W-1:0] e);
        sort_key = {~e[ENTRY_W-1], e[ENTRY_W-2:0]};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/timed_event_queue.sv =====
// Timed event queue: bounded store of pending events with schedule, remove, pop.
// Depends on tevq_pkg. Entry data sits in one memory scanned by a shared compare unit.
// Schedule and remove scan every slot before answering; a schedule with a bad id or a
// time in the past skips the scan and answers directly.
// Pop runs one full scan per emitted word, and the next scan starts when the previous
// word is taken. One memory read port paces the scan.
// One command in flight at a time. Reset (sync, active low) empties the store at once.
`default_nettype none

module timed_event_queue #(
    parameter int QUEUE_DEPTH = tevq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [tevq_pkg::CMD_W-1:0]         i_command,
    input  wire logic [tevq_pkg::ID_W-1:0]          i_event_id,
    input  wire logic [tevq_pkg::ID_W-1:0]          i_arrive_id,
    input  wire logic signed [tevq_pkg::TIME_W-1:0] i_execute_at,
    input  wire logic signed [tevq_pkg::TIME_W-1:0] i_now_time,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [tevq_pkg::STAT_W-1:0]             o_status,
    output logic [tevq_pkg::ID_W-1:0]               o_out_event_id,
    output logic [tevq_pkg::ID_W-1:0]               o_out_arrive_id,
    output logic signed [tevq_pkg::TIME_W-1:0]      o_out_execute_at,
    output logic                                    o_last
);
    import tevq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] LAST_ADDR = CW'(QUEUE_DEPTH);

    t_state r_state, n_state;

    logic [ENTRY_W-1:0] r_mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] r_rd;
    logic [QUEUE_DEPTH-1:0] r_valid;

    t_cmd                r_cmd;
    logic [ID_W-1:0]     r_ev;
    logic [ID_W-1:0]     r_ar;
    logic [TIME_W-1:0]   r_at;
    logic signed [TIME_W-1:0] r_limit;

    logic [CW-1:0]      r_addr;
    logic               r_pend;
    logic [AW-1:0]      r_pend_idx;
    logic               r_hit;
    logic               r_multi;
    logic [AW-1:0]      r_hit_idx;
    logic [ENTRY_W-1:0] r_best;
    logic               r_free_found;
    logic [AW-1:0]      r_free_idx;

    logic [STAT_W-1:0]  r_status;
    logic [ID_W-1:0]    r_oev;
    logic [ID_W-1:0]    r_oar;
    logic [TIME_W-1:0]  r_oat;
    logic               r_last;

    logic in_acc, out_acc, issue, scan_end;
    logic rd_valid, id_match, due, earlier;
    logic sched_bad, sched_past;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign in_acc   = i_valid && o_ready;
    assign out_acc  = o_valid && i_ready;
    assign issue    = (r_state == S_SCAN) && (r_addr != LAST_ADDR);
    assign scan_end = (r_state == S_SCAN) && (r_addr == LAST_ADDR) && !r_pend;

    assign sched_bad  = (i_event_id == '0) || (i_arrive_id == '0);
    assign sched_past = (i_execute_at < i_now_time);

    // Shared compare unit on the entry just read
    assign rd_valid = r_pend && r_valid[r_pend_idx];
    assign id_match = (r_rd[ID_W-1:0] == r_ev);
    assign due      = ($signed(r_rd[ENTRY_W-1 -: TIME_W]) <= r_limit);
    assign earlier  = (sort_key(r_rd) < sort_key(r_best));

    assign o_status         = r_status;
    assign o_out_event_id   = r_oev;
    assign o_out_arrive_id  = r_oar;
    assign o_out_execute_at = $signed(r_oat);
    assign o_last           = r_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_cmd'(i_command))
                        CMD_SCHEDULE: n_state = (sched_bad || sched_past) ? S_OUT : S_SCAN;
                        CMD_REMOVE:   n_state = S_SCAN;
                        CMD_POP:      n_state = S_SCAN;
                        CMD_NONE:     n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: if (scan_end) n_state = S_DONE;
            S_DONE: n_state = S_OUT;
            S_OUT: begin
                if (out_acc) begin
                    n_state = (r_cmd == CMD_POP && !r_last) ? S_SCAN : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && r_cmd == CMD_SCHEDULE && !r_hit && r_free_found) begin
            r_mem[r_free_idx] <= {r_at, r_ar, r_ev};
        end
        if (issue) begin
            r_rd <= r_mem[r_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;

            // Scan pipeline: address out this cycle, data back the next
            r_pend <= issue;
            if (issue) begin
                r_pend_idx <= r_addr[AW-1:0];
                r_addr     <= r_addr + 1'b1;
            end

            if (rd_valid) begin
                unique case (r_cmd)
                    CMD_SCHEDULE: if (id_match) r_hit <= 1'b1;
                    CMD_REMOVE: begin
                        if (id_match) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_pend_idx;
                            r_best    <= r_rd;
                        end
                    end
                    CMD_POP: begin
                        if (due) begin
                            if (r_hit) r_multi <= 1'b1;
                            if (!r_hit || earlier) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= r_pend_idx;
                                r_best    <= r_rd;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            // Lowest free slot, for schedule
            if (r_pend && !r_valid[r_pend_idx] && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_pend_idx;
            end

            if (in_acc) begin
                r_cmd   <= t_cmd'(i_command);
                r_ev    <= i_event_id;
                r_ar    <= i_arrive_id;
                r_at    <= i_execute_at;
                r_limit <= i_now_time;
                r_status <= sched_bad ? STAT_BAD_ID : STAT_IN_PAST;
                r_oev   <= '0;
                r_oar   <= '0;
                r_oat   <= '0;
                r_last  <= 1'b1;
            end

            // Clear scan state on every scan start
            if ((r_state == S_IDLE && n_state == S_SCAN) ||
                (r_state == S_OUT && n_state == S_SCAN)) begin
                r_addr       <= '0;
                r_hit        <= 1'b0;
                r_multi      <= 1'b0;
                r_free_found <= 1'b0;
            end

            if (r_state == S_DONE) begin
                r_oev  <= '0;
                r_oar  <= '0;
                r_oat  <= '0;
                r_last <= 1'b1;
                unique case (r_cmd)
                    CMD_SCHEDULE: begin
                        if (r_hit) begin
                            r_status <= STAT_DUPLICATE;
                        end else if (!r_free_found) begin
                            r_status <= STAT_FULL;
                        end else begin
                            r_status <= STAT_OK;
                            r_valid[r_free_idx] <= 1'b1;
                        end
                    end
                    CMD_REMOVE, CMD_POP: begin
                        if (r_hit) begin
                            r_status <= STAT_OK;
                            r_valid[r_hit_idx] <= 1'b0;
                            r_oev  <= r_best[ID_W-1:0];
                            r_oar  <= r_best[2*ID_W-1:ID_W];
                            r_oat  <= r_best[ENTRY_W-1 -: TIME_W];
                            r_last <= (r_cmd == CMD_POP) ? !r_multi : 1'b1;
                        end else begin
                            r_status <= (r_cmd == CMD_POP) ? STAT_NONE_DUE : STAT_NOT_FOUND;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tevq_checker.sv =====
// Port-level checker for timed_event_queue, bound to every instance.
// Depends on tevq_pkg for widths and status codes.
`default_nettype none

module tevq_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_ready,
    input wire logic                               o_valid,
    input wire logic                               i_ready,
    input wire logic [tevq_pkg::STAT_W-1:0]        o_status,
    input wire logic [tevq_pkg::ID_W-1:0]          o_out_event_id,
    input wire logic [tevq_pkg::ID_W-1:0]          o_out_arrive_id,
    input wire logic signed [tevq_pkg::TIME_W-1:0] o_out_execute_at,
    input wire logic                               o_last
);
    import tevq_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_last)
            && $stable(o_out_event_id))
        else $error("result word changed while stalled");

    // No new command while a result is pending
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("command accepted while result pending");

    // Only popped events continue a burst
    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_status == STAT_OK)
        else $error("non-final word with error status");

    // Error and none-due words carry zero payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STAT_OK |-> o_out_event_id == '0
            && o_out_arrive_id == '0 && o_out_execute_at == '0)
        else $error("error word with nonzero payload");

endmodule

bind timed_event_queue tevq_checker u_tevq_checker (.*);

`default_nettype wire
